// ===== design/msp_frame_receiver_macros.svh =====
// assertion macros shared by the frame receiver modules
`ifndef MSP_FRAME_RECEIVER_MACROS_SVH
`define MSP_FRAME_RECEIVER_MACROS_SVH

// property must hold at every clock edge outside reset
`define MSP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("msp assertion failed");

// condition must never be seen outside reset
`define MSP_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("msp forbidden condition seen");

`endif

// ===== design/msp_pkg.sv =====
// types, constants and crc function for the frame receiver
package msp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIR_M,
		ST_DIR_X,
		ST_HDR_V1,
		ST_PAY_V1,
		ST_CK_V1,
		ST_HDR_TUN,
		ST_PAY_TUN,
		ST_CK_TUN,
		ST_HDR_V2,
		ST_PAY_V2,
		ST_CK_V2
	} state_t;

	typedef enum logic [2:0] {
		KIND_DATA,
		KIND_OK,
		KIND_CKSUM,
		KIND_SIZE,
		KIND_HDR
	} kind_t;

	localparam logic [1:0] VER_V1  = 2'd0;
	localparam logic [1:0] VER_TUN = 2'd1;
	localparam logic [1:0] VER_V2  = 2'd2;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_M       = 8'h4D;
	localparam logic [7:0] CH_X       = 8'h58;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] TUNNEL_CMD = 8'hFF;
	localparam logic [7:0] CRC_POLY   = 8'hD5;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd192;
	localparam logic [7:0]  TUN_MIN_SIZE    = 8'd6;
	localparam int          HDR_DEPTH       = 7;
	localparam logic [15:0] V1_HDR_LEN      = 16'd2;
	localparam logic [15:0] TUN_HDR_END     = 16'd7;
	localparam logic [15:0] V2_HDR_LEN      = 16'd5;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] command_id;
		logic [7:0]  frame_flags;
		logic [15:0] payload_length;
		logic        is_reply;
		logic [1:0]  version;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

// ===== design/msp_fsm.sv =====
// frame parser: state, header store, checksums and result formation
module msp_fsm
	import msp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte_s1,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        res_valid,
	output res_t        res
);

	state_t      state_q, state_n;
	logic [15:0] count_q, count_n;
	logic [7:0]  xor_q, xor_n;
	logic [7:0]  crc_q, crc_n;
	logic [15:0] size_q, size_n;
	logic [15:0] cmd_q, cmd_n;
	logic [7:0]  flags_q, flags_n;
	logic        reply_q, reply_n;
	logic [1:0]  version_q, version_n;
	logic [15:0] max_payload_q;
	logic [7:0]  hdr_q [HDR_DEPTH];
	logic [7:0]  hb [HDR_DEPTH];
	logic        hdr_we;
	logic [15:0] cnt_inc;
	logic [7:0]  crc_next;
	kind_t       kind;
	logic [7:0]  data;
	logic [15:0] idx;
	logic        emit;
	logic [7:0]  c;

	assign c        = rx_byte_s1;
	assign cnt_inc  = count_q + 16'd1;
	assign crc_next = crc8_step(crc_q, c);

	// header bytes with the current byte forwarded into its slot
	always_comb begin
		for (int i = 0; i < HDR_DEPTH; i++) begin
			hb[i] = (count_q == 16'(i)) ? c : hdr_q[i];
		end
	end

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		xor_n     = xor_q;
		crc_n     = crc_q;
		size_n    = size_q;
		cmd_n     = cmd_q;
		flags_n   = flags_q;
		reply_n   = reply_q;
		version_n = version_q;
		hdr_we    = 1'b0;
		emit      = 1'b0;
		kind      = KIND_DATA;
		data      = 8'd0;
		idx       = 16'd0;
		unique case (state_q)
			ST_START: begin
				count_n   = 16'd0;
				xor_n     = 8'd0;
				crc_n     = 8'd0;
				size_n    = 16'd0;
				cmd_n     = 16'd0;
				flags_n   = 8'd0;
				reply_n   = 1'b0;
				version_n = VER_V1;
				if (c == CH_M) begin
					state_n = ST_DIR_M;
				end else if (c == CH_X) begin
					state_n   = ST_DIR_X;
					version_n = VER_V2;
				end else begin
					state_n = ST_IDLE;
					emit    = 1'b1;
					kind    = KIND_HDR;
				end
			end
			ST_DIR_M, ST_DIR_X: begin
				if (c != CH_LT && c != CH_GT) begin
					state_n = ST_IDLE;
					emit    = 1'b1;
					kind    = KIND_HDR;
				end else begin
					reply_n = (c == CH_GT);
					state_n = (state_q == ST_DIR_M) ? ST_HDR_V1 : ST_HDR_V2;
				end
			end
			ST_HDR_V1: begin
				hdr_we  = 1'b1;
				count_n = cnt_inc;
				xor_n   = xor_q ^ c;
				if (cnt_inc == V1_HDR_LEN) begin
					size_n  = {8'd0, hb[0]};
					cmd_n   = {8'd0, hb[1]};
					flags_n = 8'd0;
					if ({8'd0, hb[0]} > max_payload_q) begin
						state_n = ST_IDLE;
						emit    = 1'b1;
						kind    = KIND_SIZE;
					end else if (hb[1] == TUNNEL_CMD) begin
						if (hb[0] < TUN_MIN_SIZE) begin
							state_n = ST_IDLE;
							emit    = 1'b1;
							kind    = KIND_HDR;
						end else begin
							version_n = VER_TUN;
							state_n   = ST_HDR_TUN;
						end
					end else begin
						count_n = 16'd0;
						state_n = (hb[0] != 8'd0) ? ST_PAY_V1 : ST_CK_V1;
					end
				end
			end
			ST_PAY_V1: begin
				xor_n   = xor_q ^ c;
				emit    = 1'b1;
				data    = c;
				idx     = count_q;
				count_n = cnt_inc;
				if (cnt_inc == size_q) begin
					state_n = ST_CK_V1;
				end
			end
			ST_CK_V1: begin
				state_n = ST_IDLE;
				emit    = 1'b1;
				kind    = (xor_q == c) ? KIND_OK : KIND_CKSUM;
			end
			ST_HDR_TUN: begin
				hdr_we  = 1'b1;
				count_n = cnt_inc;
				xor_n   = xor_q ^ c;
				crc_n   = crc_next;
				if (cnt_inc == TUN_HDR_END) begin
					flags_n = hb[2];
					cmd_n   = {hb[4], hb[3]};
					size_n  = {hb[6], hb[5]};
					count_n = 16'd0;
					if ({hb[6], hb[5]} > max_payload_q) begin
						state_n = ST_IDLE;
						emit    = 1'b1;
						kind    = KIND_SIZE;
					end else begin
						state_n = ({hb[6], hb[5]} != 16'd0) ? ST_PAY_TUN : ST_CK_TUN;
					end
				end
			end
			ST_PAY_TUN: begin
				xor_n   = xor_q ^ c;
				crc_n   = crc_next;
				emit    = 1'b1;
				data    = c;
				idx     = count_q;
				count_n = cnt_inc;
				if (cnt_inc == size_q) begin
					state_n = ST_CK_TUN;
				end
			end
			ST_CK_TUN: begin
				xor_n = xor_q ^ c;
				if (crc_q != c) begin
					state_n = ST_IDLE;
					emit    = 1'b1;
					kind    = KIND_CKSUM;
				end else begin
					state_n = ST_CK_V1;
				end
			end
			ST_HDR_V2: begin
				hdr_we  = 1'b1;
				count_n = cnt_inc;
				crc_n   = crc_next;
				if (cnt_inc == V2_HDR_LEN) begin
					flags_n = hb[0];
					cmd_n   = {hb[2], hb[1]};
					size_n  = {hb[4], hb[3]};
					count_n = 16'd0;
					if ({hb[4], hb[3]} > max_payload_q) begin
						state_n = ST_IDLE;
						emit    = 1'b1;
						kind    = KIND_SIZE;
					end else begin
						state_n = ({hb[4], hb[3]} != 16'd0) ? ST_PAY_V2 : ST_CK_V2;
					end
				end
			end
			ST_PAY_V2: begin
				crc_n   = crc_next;
				emit    = 1'b1;
				data    = c;
				idx     = count_q;
				count_n = cnt_inc;
				if (cnt_inc == size_q) begin
					state_n = ST_CK_V2;
				end
			end
			ST_CK_V2: begin
				state_n = ST_IDLE;
				emit    = 1'b1;
				kind    = (crc_q == c) ? KIND_OK : KIND_CKSUM;
			end
			default: begin
				state_n = (c == CH_DOLLAR) ? ST_START : ST_IDLE;
			end
		endcase
	end

	assign res_valid          = emit;
	assign res.kind           = kind;
	assign res.data_byte      = data;
	assign res.byte_index     = idx;
	assign res.command_id     = cmd_n;
	assign res.frame_flags    = flags_n;
	assign res.payload_length = size_n;
	assign res.is_reply       = reply_n;
	assign res.version        = version_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= 16'd0;
			xor_q     <= 8'd0;
			crc_q     <= 8'd0;
			size_q    <= 16'd0;
			cmd_q     <= 16'd0;
			flags_q   <= 8'd0;
			reply_q   <= 1'b0;
			version_q <= VER_V1;
		end else if (step) begin
			state_q   <= state_n;
			count_q   <= count_n;
			xor_q     <= xor_n;
			crc_q     <= crc_n;
			size_q    <= size_n;
			cmd_q     <= cmd_n;
			flags_q   <= flags_n;
			reply_q   <= reply_n;
			version_q <= version_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// header store, no reset
	always_ff @(posedge clk) begin
		if (step && hdr_we && count_q < 16'(HDR_DEPTH)) begin
			hdr_q[count_q[2:0]] <= c;
		end
	end

`include "msp_frame_receiver_macros.svh"

	`MSP_ASSERT(a_close_to_idle, step && res_valid && res.kind != KIND_DATA |=> state_q == ST_IDLE)
	`MSP_NEVER(a_index_in_range, step && res_valid && res.kind == KIND_DATA && res.byte_index >= res.payload_length)
	`MSP_NEVER(a_payload_nonzero, (state_q == ST_PAY_V1 || state_q == ST_PAY_V2 || state_q == ST_PAY_TUN) && size_q == 16'd0)

endmodule

// ===== design/msp_out_reg.sv =====
// result register toward the output channel
module msp_out_reg
	import msp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_ready,
	output logic out_valid,
	output logic free,
	output res_t res_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== design/msp_frame_receiver.sv =====
// top level of the frame receiver: input register, parser, result register
//
// channel   signals                     dir   beat
// in        in_valid/in_ready           in    rx_byte
// out       out_valid/out_ready         out   kind ... version
// cfg       cfg_we/cfg_wdata            in    max_payload, no wait
//
// one byte per cycle sustained while the result register is free
// the input register and the parser state update advance together, gated by the result register
// a byte that causes no result still passes only when the result register is free
// reset clears state, checksums and limit (192); header store holds no reset value
// output stall backs up through the input register to in_ready in the same cycle
module msp_frame_receiver
	import msp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic [15:0] command_id,
	output logic [7:0]  frame_flags,
	output logic [15:0] payload_length,
	output logic        is_reply,
	output logic [1:0]  version,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_free;
	logic       step;
	logic       res_valid;
	res_t       res;
	res_t       res_q;

	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	msp_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	msp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res_in    (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.res_q     (res_q)
	);

	assign kind           = res_q.kind;
	assign data_byte      = res_q.data_byte;
	assign byte_index     = res_q.byte_index;
	assign command_id     = res_q.command_id;
	assign frame_flags    = res_q.frame_flags;
	assign payload_length = res_q.payload_length;
	assign is_reply       = res_q.is_reply;
	assign version        = res_q.version;

`include "msp_frame_receiver_macros.svh"

	`MSP_ASSERT(a_s1_held, valid_s1 && !out_free |=> valid_s1 && $stable(rx_byte_s1))
	`MSP_ASSERT(a_ready_when_free, out_free |-> in_ready)
	`MSP_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid && $stable(res_q))

endmodule

// ===== tb/msp_frame_checker.sv =====
// frame receiver checker: mirrors the parser, predicts each result beat and compares it
`timescale 1ns / 1ps

module msp_frame_checker
	import msp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] byte_index,
	input  logic [15:0] command_id,
	input  logic [7:0]  frame_flags,
	input  logic [15:0] payload_length,
	input  logic        is_reply,
	input  logic [1:0]  version,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatches,
	output int          outstanding,
	output logic        frame_open
);

	state_t      ps;
	logic [15:0] pos;
	logic [15:0] size_q;
	logic [15:0] cmd_q;
	logic [15:0] max_len;
	logic [7:0]  xor_acc;
	logic [7:0]  crc_acc;
	logic [7:0]  flags_q;
	logic [7:0]  hdr_bytes [HDR_DEPTH];
	logic        reply_q;
	logic [1:0]  ver_q;
	res_t        predicted [$];
	res_t        want;

	assign frame_open = (ps != ST_IDLE);

	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = {r[6:0], 1'b0} ^ ({8{r[7]}} & CRC_POLY);
		return r;
	endfunction

	function automatic void post(input kind_t k, input logic [7:0] d, input logic [15:0] idx);
		res_t r;
		r.kind = k;
		r.data_byte = d;
		r.byte_index = idx;
		r.command_id = cmd_q;
		r.frame_flags = flags_q;
		r.payload_length = size_q;
		r.is_reply = reply_q;
		r.version = ver_q;
		predicted.push_back(r);
	endfunction

	function automatic void close_frame(input kind_t k);
		ps = ST_IDLE;
		post(k, 8'h00, 16'h0000);
	endfunction

	function automatic void keep_header(input logic [7:0] c);
		if (pos < HDR_DEPTH)
			hdr_bytes[pos[2:0]] = c;
		pos = pos + 16'd1;
	endfunction

	function automatic void load_inner(input int base);
		flags_q = hdr_bytes[base];
		cmd_q = {hdr_bytes[base + 2], hdr_bytes[base + 1]};
		size_q = {hdr_bytes[base + 4], hdr_bytes[base + 3]};
		pos = 16'd0;
	endfunction

	function automatic void payload_byte(input logic [7:0] c, input state_t after);
		logic [15:0] idx;
		idx = pos;
		pos = pos + 16'd1;
		if (pos == size_q)
			ps = after;
		post(KIND_DATA, c, idx);
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		case (ps)
			ST_START: begin
				pos = 16'd0;
				xor_acc = 8'h00;
				crc_acc = 8'h00;
				size_q = 16'd0;
				cmd_q = 16'd0;
				flags_q = 8'h00;
				reply_q = 1'b0;
				if (c == CH_M) begin
					ps = ST_DIR_M;
					ver_q = VER_V1;
				end else if (c == CH_X) begin
					ps = ST_DIR_X;
					ver_q = VER_V2;
				end else begin
					ver_q = VER_V1;
					close_frame(KIND_HDR);
				end
			end
			ST_DIR_M, ST_DIR_X: begin
				if (c != CH_LT && c != CH_GT) begin
					close_frame(KIND_HDR);
				end else begin
					reply_q = (c == CH_GT);
					ps = (ps == ST_DIR_M) ? ST_HDR_V1 : ST_HDR_V2;
				end
			end
			ST_HDR_V1: begin
				keep_header(c);
				xor_acc = xor_acc ^ c;
				if (pos == V1_HDR_LEN) begin
					size_q = {8'h00, hdr_bytes[0]};
					cmd_q = {8'h00, hdr_bytes[1]};
					flags_q = 8'h00;
					if (size_q > max_len) begin
						close_frame(KIND_SIZE);
					end else if (cmd_q == TUNNEL_CMD) begin
						if (size_q < TUN_MIN_SIZE) begin
							close_frame(KIND_HDR);
						end else begin
							ver_q = VER_TUN;
							ps = ST_HDR_TUN;
						end
					end else begin
						pos = 16'd0;
						ps = (size_q != 16'd0) ? ST_PAY_V1 : ST_CK_V1;
					end
				end
			end
			ST_PAY_V1: begin
				xor_acc = xor_acc ^ c;
				payload_byte(c, ST_CK_V1);
			end
			ST_CK_V1: close_frame((xor_acc == c) ? KIND_OK : KIND_CKSUM);
			ST_HDR_TUN: begin
				keep_header(c);
				xor_acc = xor_acc ^ c;
				crc_acc = crc_next(crc_acc, c);
				if (pos == TUN_HDR_END) begin
					load_inner(2);
					if (size_q > max_len)
						close_frame(KIND_SIZE);
					else
						ps = (size_q != 16'd0) ? ST_PAY_TUN : ST_CK_TUN;
				end
			end
			ST_PAY_TUN: begin
				xor_acc = xor_acc ^ c;
				crc_acc = crc_next(crc_acc, c);
				payload_byte(c, ST_CK_TUN);
			end
			ST_CK_TUN: begin
				xor_acc = xor_acc ^ c;
				if (crc_acc != c)
					close_frame(KIND_CKSUM);
				else
					ps = ST_CK_V1;
			end
			ST_HDR_V2: begin
				keep_header(c);
				crc_acc = crc_next(crc_acc, c);
				if (pos == V2_HDR_LEN) begin
					load_inner(0);
					if (size_q > max_len)
						close_frame(KIND_SIZE);
					else
						ps = (size_q != 16'd0) ? ST_PAY_V2 : ST_CK_V2;
				end
			end
			ST_PAY_V2: begin
				crc_acc = crc_next(crc_acc, c);
				payload_byte(c, ST_CK_V2);
			end
			ST_CK_V2: close_frame((crc_acc == c) ? KIND_OK : KIND_CKSUM);
			default: ps = (c == CH_DOLLAR) ? ST_START : ST_IDLE;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps = ST_IDLE;
			pos = 16'd0;
			size_q = 16'd0;
			cmd_q = 16'd0;
			max_len = MAX_PAYLOAD_RST;
			xor_acc = 8'h00;
			crc_acc = 8'h00;
			flags_q = 8'h00;
			reply_q = 1'b0;
			ver_q = VER_V1;
			foreach (hdr_bytes[i])
				hdr_bytes[i] = 8'h00;
			predicted.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (predicted.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, kind %0d", $time, kind);
				end else begin
					want = predicted.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
					check_field("byte_index", want.byte_index, byte_index);
					check_field("command_id", want.command_id, command_id);
					check_field("frame_flags", 16'(want.frame_flags), 16'(frame_flags));
					check_field("payload_length", want.payload_length, payload_length);
					check_field("is_reply", 16'(want.is_reply), 16'(is_reply));
					check_field("version", 16'(want.version), 16'(version));
				end
			end
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			if (cfg_we)
				max_len = cfg_wdata;
		end
		outstanding = predicted.size();
	end

endmodule

// ===== tb/testbench.sv =====
// frame receiver testbench top: clock, reset, byte stimulus, config phases and verdict
`timescale 1ns / 1ps

module testbench;
	import msp_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int PHASE_BYTES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] command_id;
	logic [7:0]  frame_flags;
	logic [15:0] payload_length;
	logic        is_reply;
	logic [1:0]  version;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          mismatches;
	int          outstanding;
	logic        frame_open;

	logic [15:0] cur_limit;
	logic [7:0]  tx_q [$];
	int          send_mode;
	int          take_mode;
	int          bytes_sent;
	int          quiet_cycles;

	msp_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.command_id(command_id),
		.frame_flags(frame_flags),
		.payload_length(payload_length),
		.is_reply(is_reply),
		.version(version),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	msp_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.command_id(command_id),
		.frame_flags(frame_flags),
		.payload_length(payload_length),
		.is_reply(is_reply),
		.version(version),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.frame_open(frame_open)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 12);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
		endcase
	endfunction

	function automatic logic [7:0] crc_add(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = {r[6:0], 1'b0} ^ ({8{r[7]}} & CRC_POLY);
		return r;
	endfunction

	// payload is only appended when the header sizes pass the current limit
	function automatic void build_frame(input logic [1:0] ver, input logic gt,
			input logic [15:0] cmd, input logic [7:0] flg, input logic [15:0] len,
			input logic [7:0] outer);
		logic [7:0] x;
		logic [7:0] c;
		logic [7:0] b;
		logic [7:0] hdr [5];
		tx_q.delete();
		x = 8'h00;
		c = 8'h00;
		tx_q.push_back(CH_DOLLAR);
		tx_q.push_back((ver == VER_V2) ? CH_X : CH_M);
		tx_q.push_back(gt ? CH_GT : CH_LT);
		if (ver == VER_V1) begin
			tx_q.push_back(len[7:0]);
			tx_q.push_back(cmd[7:0]);
			x = len[7:0] ^ cmd[7:0];
			if (len > cur_limit)
				return;
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom);
				tx_q.push_back(b);
				x = x ^ b;
			end
			tx_q.push_back(x);
			return;
		end
		if (ver == VER_TUN) begin
			tx_q.push_back(outer);
			tx_q.push_back(TUNNEL_CMD);
			x = outer ^ TUNNEL_CMD;
			if (outer > cur_limit || outer < TUN_MIN_SIZE)
				return;
		end
		hdr = '{flg, cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
		foreach (hdr[i]) begin
			tx_q.push_back(hdr[i]);
			x = x ^ hdr[i];
			c = crc_add(c, hdr[i]);
		end
		if (len > cur_limit)
			return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			tx_q.push_back(b);
			x = x ^ b;
			c = crc_add(c, b);
		end
		tx_q.push_back(c);
		if (ver == VER_TUN)
			tx_q.push_back(x ^ c);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(send_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (tx_q[i])
			send_byte(tx_q[i]);
	endtask

	// hold off until every predicted result beat is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		settle();
		while (frame_open) begin
			send_byte(8'h00);
			settle();
		end
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cur_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		take_mode = 1;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				take_mode = $urandom_range(0, 2);
			stall = pick_gap(take_mode);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int phase_end;
		int pick;
		int n;
		int cut;
		logic [1:0]  ver;
		logic        gt;
		logic        risky_ok;
		logic [15:0] cmd;
		logic [15:0] len;
		logic [7:0]  flg;
		logic [7:0]  outer;
		logic [7:0]  b;
		logic [15:0] phase_limit [6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = 16'h0000;
		cur_limit = MAX_PAYLOAD_RST;
		send_mode = 1;
		bytes_sent = 0;
		phase_limit = '{MAX_PAYLOAD_RST, 16'd0, 16'hFFFF, 16'd8, 16'd0, MAX_PAYLOAD_RST};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while idle, second dollar, bad direction
		send_byte(8'hA5);
		send_byte(CH_DOLLAR);
		send_byte(CH_DOLLAR);
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(8'h00);
		// zero size v1, short tunnel, oversize native v2 with all-ones fields
		build_frame(VER_V1, 1'b0, 16'h0000, 8'h00, 16'h0000, 8'h00);
		send_frame();
		build_frame(VER_TUN, 1'b1, 16'h0000, 8'h00, 16'h0000, 8'h03);
		send_frame();
		build_frame(VER_V2, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 8'h00);
		send_frame();

		foreach (phase_limit[p]) begin
			write_limit((p == 4) ? 16'($urandom_range(9, 1024)) : phase_limit[p]);
			risky_ok = (cur_limit <= 16'd1024);
			if (cur_limit == 16'hFFFF) begin
				send_mode = 0;
				build_frame(VER_V2, 1'b0, 16'($urandom), 8'($urandom), 16'd300, 8'h00);
				send_frame();
				send_mode = 1;
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 7) == 0)
					send_mode = $urandom_range(0, 2);
				if ($urandom_range(0, 39) == 0)
					settle();
				if (risky_ok && $urandom_range(0, 99) < 15) begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						case ($urandom_range(0, 5))
							0: b = CH_DOLLAR;
							1: b = CH_M;
							2: b = CH_X;
							3: b = CH_LT;
							4: b = CH_GT;
							default: b = 8'($urandom);
						endcase
						send_byte(b);
					end
				end else begin
					ver = 2'($urandom_range(VER_V1, VER_V2));
					gt = 1'($urandom_range(0, 1));
					flg = 8'($urandom);
					cmd = 16'($urandom);
					if (ver == VER_V1) begin
						cmd[15:8] = 8'h00;
						if (!risky_ok && cmd[7:0] == TUNNEL_CMD)
							cmd[7:0] = 8'h00;
					end
					pick = $urandom_range(0, 19);
					if (pick == 0 && cur_limit != 16'hFFFF) begin
						len = ($urandom_range(0, 1) != 0) ? cur_limit + 16'd1 : 16'hFFFF;
					end else if (pick == 1) begin
						len = (cur_limit < 16'd64) ? cur_limit : 16'($urandom_range(20, 64));
					end else begin
						len = 16'($urandom_range(0, 10));
						if (len > cur_limit)
							len = cur_limit;
					end
					if (ver == VER_V1 && len > 16'd255)
						len = 16'd255;
					outer = (len > 16'd249) ? 8'hFF : 8'(len + 16'd6);
					if ($urandom_range(0, 9) == 0)
						outer = 8'($urandom);
					build_frame(ver, gt, cmd, flg, len, outer);
					if (risky_ok) begin
						case ($urandom_range(0, 9))
							0: tx_q[tx_q.size() - 1] = tx_q[tx_q.size() - 1]
								^ 8'($urandom_range(1, 255));
							1: begin
								pick = $urandom_range(0, tx_q.size() - 1);
								tx_q[pick] = tx_q[pick] ^ 8'($urandom_range(1, 255));
							end
							2: begin
								cut = $urandom_range(1, tx_q.size() - 1);
								while (tx_q.size() > cut)
									void'(tx_q.pop_back());
							end
							3: tx_q[tx_q.size() - 2] = tx_q[tx_q.size() - 2]
								^ 8'($urandom_range(1, 255));
							default: ;
						endcase
					end
					send_frame();
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
